>>> design/gesmo_pkg.sv
// Shared types and constants for the Gaussian edge-shrinking smoother.
// Holds register indexes, reset weights and the tap control bundle.
// No dependencies; every other design file but gesmo_cell imports this package.
package gesmo_pkg;

  // default values of the top level parameters
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int MAX_RADIUS_DEF  = 6;
  localparam int MAX_LENGTH_DEF  = 4096;

  // fixed field widths
  localparam int POS_W     = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;
  localparam int RADIUS_W  = 3;
  localparam int WEIGHT_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_0 = 3'd1;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd5;

  // Gaussian weights after reset, distance zero first, units of 1/32768
  localparam int NUM_RESET_WEIGHTS = 7;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET [NUM_RESET_WEIGHTS] = '{
    16'd32768, 16'd28918, 16'd19874, 16'd10640, 16'd4435, 16'd1439, 16'd364
  };

  // one tap of a window sweep, from the sequencer to the MAC
  typedef struct packed {
    logic                vld;
    logic                first;
    logic                last;
    logic                incl;
    logic                center;
    logic [WEIGHT_W-1:0] w;
  } tap_t;

endpackage

>>> design/gesmo_cell.sv
// One cell of the sample ring: holds one sample and takes its neighbor's
// sample whenever the ring advances. Depends on nothing.
module gesmo_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          adv_i,
  input  logic signed [SAMPLE_BITS-1:0] d_i,
  output logic signed [SAMPLE_BITS-1:0] q_o
);

  logic signed [SAMPLE_BITS-1:0] smp_q;
  logic signed [SAMPLE_BITS-1:0] smp_d;

  // take the neighbor on advance, hold otherwise
  always_comb begin
    smp_d = adv_i ? d_i : smp_q;
  end

  always_ff @(posedge clk_i) begin
    smp_q <= smp_d;
  end

  assign q_o = smp_q;

endmodule

>>> design/gesmo_mac.sv
// Multiply-accumulate unit for one window sweep: weighted sample sum,
// weight sum and center sample capture. Depends on gesmo_pkg (tap_t).
module gesmo_mac #(
  parameter int SAMPLE_BITS = 16,
  parameter int WIN_DEPTH   = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gesmo_pkg::tap_t               tap_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS+gesmo_pkg::WEIGHT_W+$clog2(WIN_DEPTH):0] num_o,
  output logic [gesmo_pkg::WEIGHT_W+$clog2(WIN_DEPTH)-1:0] den_o,
  output logic signed [SAMPLE_BITS-1:0] center_o
);
  import gesmo_pkg::*;

  localparam int T_W    = $clog2(WIN_DEPTH);
  localparam int PROD_W = SAMPLE_BITS + WEIGHT_W + 1;
  localparam int ACC_W  = PROD_W + T_W;
  localparam int DEN_W  = WEIGHT_W + T_W;

  logic signed [PROD_W-1:0]      prod_q, prod_d;
  logic [WEIGHT_W-1:0]           w_q;
  logic                          vld_q, first_q, last_q;
  logic signed [SAMPLE_BITS-1:0] center_q, center_d;
  logic signed [ACC_W-1:0]       num_q, num_d;
  logic [DEN_W-1:0]              den_q, den_d;
  logic                          done_q;

  // stage one: product of head sample and tap weight, dropped taps give zero
  always_comb begin
    if (tap_i.incl) begin
      prod_d = $signed(sample_i) * $signed({1'b0, tap_i.w});
    end else begin
      prod_d = '0;
    end
    center_d = (tap_i.vld && tap_i.center) ? sample_i : center_q;
  end

  // stage two: accumulate, restarting on the first tap of a sweep
  always_comb begin
    num_d = num_q;
    den_d = den_q;
    if (vld_q) begin
      if (first_q) begin
        num_d = ACC_W'(prod_q);
        den_d = DEN_W'(w_q);
      end else begin
        num_d = num_q + ACC_W'(prod_q);
        den_d = den_q + DEN_W'(w_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= tap_i.vld;
      done_q <= vld_q && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    w_q      <= tap_i.incl ? tap_i.w : '0;
    first_q  <= tap_i.first;
    last_q   <= tap_i.last;
    center_q <= center_d;
    num_q    <= num_d;
    den_q    <= den_d;
  end

  assign done_o   = done_q;
  assign num_o    = num_q;
  assign den_o    = den_q;
  assign center_o = center_q;

endmodule

>>> design/gesmo_div.sv
// Restoring divider with round-half-away-from-zero and saturation: turns
// a weighted sum and a weight sum into one average. Depends on gesmo_pkg.
module gesmo_div #(
  parameter int SAMPLE_BITS = 16,
  parameter int WIN_DEPTH   = 13
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SAMPLE_BITS+gesmo_pkg::WEIGHT_W+$clog2(WIN_DEPTH):0] num_i,
  input  logic [gesmo_pkg::WEIGHT_W+$clog2(WIN_DEPTH)-1:0] den_i,
  input  logic signed [SAMPLE_BITS-1:0] center_i,
  output logic                          done_o,
  output logic signed [SAMPLE_BITS-1:0] res_o
);
  import gesmo_pkg::*;

  localparam int T_W    = $clog2(WIN_DEPTH);
  localparam int ACC_W  = SAMPLE_BITS + WEIGHT_W + 1 + T_W;
  localparam int DEN_W  = WEIGHT_W + T_W;
  localparam int QB     = SAMPLE_BITS;
  localparam int DIV_W  = (ACC_W + 2 > DEN_W + QB) ? ACC_W + 2 : DEN_W + QB;
  localparam int CNT_W  = $clog2(QB + 1);

  logic                          busy_q, fin_q, done_q, neg_q;
  logic [CNT_W-1:0]              cnt_q;
  logic [DIV_W-1:0]              rem_q, rem_d;
  logic [DIV_W-1:0]              dsh_q;
  logic [QB-1:0]                 quo_q;
  logic signed [SAMPLE_BITS-1:0] res_q, res_d;
  logic [ACC_W-1:0]              mag;
  logic                          ge;

  // magnitude of the sum and one compare-subtract step
  always_comb begin
    mag   = num_i[ACC_W-1] ? ACC_W'(-num_i) : ACC_W'(num_i);
    ge    = rem_q >= dsh_q;
    rem_d = ge ? rem_q - dsh_q : rem_q;
  end

  // sign and saturate the finished quotient
  always_comb begin
    if (quo_q[QB-1]) begin
      res_d = neg_q ? {1'b1, {(SAMPLE_BITS-1){1'b0}}} : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end else if (neg_q) begin
      res_d = -$signed(quo_q);
    end else begin
      res_d = $signed(quo_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (den_i == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= CNT_W'(QB);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath: load 2|num|+den over 2den, then one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= num_i[ACC_W-1];
      rem_q <= DIV_W'({mag, 1'b0}) + DIV_W'(den_i);
      dsh_q <= DIV_W'({den_i, {QB{1'b0}}});
      quo_q <= '0;
      if (den_i == '0) begin
        res_q <= center_i;
      end
    end else if (busy_q) begin
      rem_q <= rem_d;
      dsh_q <= dsh_q >> 1;
      quo_q <= {quo_q[QB-2:0], ge};
    end else if (fin_q) begin
      res_q <= res_d;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

>>> design/gaussian_edge_shrinking_smoother.sv
// Gaussian edge-shrinking smoother. Samples of one vector arrive one beat at
// a time and enter a ring of 2*MAX_RADIUS+1 cells; output i (the weighted
// average of samples i-k..i+k, k shrunk at both vector ends) leaves as soon
// as sample i+k is in, and the pending outputs flush on the last sample.
// For each result the ring rotates once past a single multiply-accumulate
// unit, then a restoring divider produces one quotient bit per cycle. One
// sample is processed at a time; in_ready_o is high only between samples,
// while a finished result may still wait in the output register. The
// configuration port is always ready and must be written only while the
// block is idle.
// Depends on gesmo_pkg, gesmo_cell, gesmo_mac and gesmo_div.
module gaussian_edge_shrinking_smoother #(
  parameter int SAMPLE_BITS = gesmo_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_RADIUS  = gesmo_pkg::MAX_RADIUS_DEF,
  parameter int MAX_LENGTH  = gesmo_pkg::MAX_LENGTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0]       sample_i,
  input  logic                                is_last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]       smoothed_o,
  output logic [gesmo_pkg::POS_W-1:0]         position_o,
  output logic                                last_out_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [gesmo_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gesmo_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import gesmo_pkg::*;

  localparam int WIN_DEPTH = 2 * MAX_RADIUS + 1;
  localparam int RES_LIMIT = MAX_RADIUS + 1;
  localparam int LEN_W     = $clog2(MAX_LENGTH);
  localparam int EMIT_W    = LEN_W + 1;
  localparam int CW        = LEN_W + 3;
  localparam int K_W       = $clog2(MAX_RADIUS + 1);
  localparam int T_W       = $clog2(WIN_DEPTH);
  localparam int CNT_W     = $clog2(RES_LIMIT + 1);
  localparam int ACC_W     = SAMPLE_BITS + WEIGHT_W + 1 + T_W;
  localparam int DEN_W     = WEIGHT_W + T_W;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PLAN = 3'd1;
  localparam logic [2:0] S_MAC  = 3'd2;
  localparam logic [2:0] S_WAIT = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_PUT  = 3'd5;

  logic [2:0]          state_q, state_d;
  logic [RADIUS_W-1:0] radius_q;
  logic [WEIGHT_W-1:0] weight_q [MAX_RADIUS+1];

  logic [LEN_W-1:0]    recv_q, j_q;
  logic                last_q;
  logic [EMIT_W-1:0]   emit_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [K_W-1:0]      k_q;
  logic [T_W-1:0]      e_q;
  logic [T_W-1:0]      t_q, age_q;
  logic [POS_W-1:0]    pos_q;
  logic                lastout_q;

  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] out_smp_q;
  logic [POS_W-1:0]              out_pos_q;
  logic                          out_last_q;

  logic                          accept, last_in, adv, more, put;
  logic [K_W-1:0]                r_eff;
  logic [CW-1:0]                 i_c, j_c, r_c, kmin_c, e_c, kfin_c;
  logic [T_W-1:0]                tap_dist;
  logic [K_W-1:0]                widx;
  tap_t                          tap;
  logic signed [SAMPLE_BITS-1:0] ring_in;
  logic signed [SAMPLE_BITS-1:0] cell_q [WIN_DEPTH];

  logic                          mac_done, div_start, div_done;
  logic signed [ACC_W-1:0]       mac_num;
  logic [DEN_W-1:0]              mac_den;
  logic signed [SAMPLE_BITS-1:0] mac_center, div_res;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign last_in     = is_last_i || (recv_q == LEN_W'(MAX_LENGTH - 1));

  // configuration registers; a radius beyond the ring acts as the widest
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RESET;
      for (int d = 0; d <= MAX_RADIUS; d++) begin
        weight_q[d] <= WEIGHT_RESET[d];
      end
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_RADIUS) begin
        radius_q <= cfg_data_i[RADIUS_W-1:0];
      end
      for (int d = 0; d <= MAX_RADIUS; d++) begin
        if (cfg_index_i == CFG_IDX_W'(REG_WEIGHT_0 + d)) begin
          weight_q[d] <= cfg_data_i[WEIGHT_W-1:0];
        end
      end
    end
  end

  assign r_eff = (radius_q > RADIUS_W'(MAX_RADIUS)) ? K_W'(MAX_RADIUS) : K_W'(radius_q);

  // decide whether the next pending output can leave, and with which k
  always_comb begin
    i_c    = CW'(emit_q);
    j_c    = CW'(j_q);
    r_c    = CW'(r_eff);
    kmin_c = (i_c < r_c) ? i_c : r_c;
    e_c    = j_c - i_c;
    kfin_c = (last_q && (e_c < kmin_c)) ? e_c : kmin_c;
    more   = (cnt_q < CNT_W'(RES_LIMIT)) && (i_c <= j_c) &&
             (last_q || ((i_c + kmin_c) <= j_c));
  end

  // tap at the ring head: its distance from the output position picks a weight
  always_comb begin
    tap_dist   = (age_q > e_q) ? age_q - e_q : e_q - age_q;
    tap.vld    = (state_q == S_MAC);
    tap.first  = (t_q == '0);
    tap.last   = (t_q == T_W'(WIN_DEPTH - 1));
    tap.incl   = tap.vld && (tap_dist <= T_W'(k_q));
    tap.center = (tap_dist == '0);
    widx       = tap.incl ? tap_dist[K_W-1:0] : '0;
    tap.w      = tap.incl ? weight_q[widx] : '0;
  end

  // ring of cells: a new sample shifts in, a sweep rotates the ring once
  assign adv     = accept || (state_q == S_MAC);
  assign ring_in = (state_q == S_IDLE) ? sample_i : cell_q[WIN_DEPTH-1];

  for (genvar m = 0; m < WIN_DEPTH; m++) begin : g_ring
    if (m == 0) begin : g_head
      gesmo_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk_i (clk_i),
        .adv_i (adv),
        .d_i   (ring_in),
        .q_o   (cell_q[m])
      );
    end else begin : g_body
      gesmo_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
        .clk_i (clk_i),
        .adv_i (adv),
        .d_i   (cell_q[m-1]),
        .q_o   (cell_q[m])
      );
    end
  end

  gesmo_mac #(.SAMPLE_BITS(SAMPLE_BITS), .WIN_DEPTH(WIN_DEPTH)) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tap_i    (tap),
    .sample_i (cell_q[0]),
    .done_o   (mac_done),
    .num_o    (mac_num),
    .den_o    (mac_den),
    .center_o (mac_center)
  );

  assign div_start = (state_q == S_WAIT) && mac_done;

  gesmo_div #(.SAMPLE_BITS(SAMPLE_BITS), .WIN_DEPTH(WIN_DEPTH)) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .num_i    (mac_num),
    .den_i    (mac_den),
    .center_i (mac_center),
    .done_o   (div_done),
    .res_o    (div_res)
  );

  assign put = (state_q == S_PUT) && (!out_valid_q || out_ready_i);

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_PLAN;
      S_PLAN: state_d = more ? S_MAC : S_IDLE;
      S_MAC:  if (t_q == T_W'(WIN_DEPTH - 1)) state_d = S_WAIT;
      S_WAIT: if (mac_done) state_d = S_DIV;
      S_DIV:  if (div_done) state_d = S_PUT;
      S_PUT:  if (put) state_d = S_PLAN;
      default: state_d = S_IDLE;
    endcase
  end

  // control registers: counters, sweep position, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      recv_q      <= '0;
      emit_q      <= '0;
      cnt_q       <= '0;
      last_q      <= 1'b0;
      t_q         <= '0;
      age_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        last_q <= last_in;
        recv_q <= last_in ? '0 : recv_q + 1'b1;
        cnt_q  <= '0;
      end
      if (state_q == S_PLAN) begin
        t_q   <= '0;
        age_q <= '0;
        if (!more && last_q) begin
          emit_q <= '0;
        end
      end
      if (state_q == S_MAC) begin
        t_q   <= t_q + 1'b1;
        age_q <= (age_q == '0) ? T_W'(WIN_DEPTH - 1) : age_q - 1'b1;
      end
      if (put) begin
        emit_q <= emit_q + 1'b1;
        cnt_q  <= cnt_q + 1'b1;
      end
      if (put) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers: sample index, output plan, output beat
  always_ff @(posedge clk_i) begin
    if (accept) begin
      j_q <= recv_q;
    end
    if ((state_q == S_PLAN) && more) begin
      k_q       <= K_W'(kfin_c);
      e_q       <= T_W'(e_c);
      pos_q     <= POS_W'(emit_q);
      lastout_q <= last_q && (i_c == j_c);
    end
    if (put) begin
      out_smp_q  <= div_res;
      out_pos_q  <= pos_q;
      out_last_q <= lastout_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign smoothed_o  = out_smp_q;
  assign position_o  = out_pos_q;
  assign last_out_o  = out_last_q;

endmodule

>>> design/gesmo_checker.sv
// Port-level checker for the Gaussian edge-shrinking smoother, bound to the
// top level below. Depends on gesmo_pkg.
module gesmo_checker #(
  parameter int SAMPLE_BITS = gesmo_pkg::SAMPLE_BITS_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic signed [SAMPLE_BITS-1:0]   sample_i,
  input logic                            is_last_i,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input logic signed [SAMPLE_BITS-1:0]   smoothed_o,
  input logic [gesmo_pkg::POS_W-1:0]     position_o,
  input logic                            last_out_o,
  input logic                            cfg_valid_i,
  input logic                            cfg_ready_o,
  input logic [gesmo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input logic [gesmo_pkg::CFG_DAT_W-1:0] cfg_data_i
);
  import gesmo_pkg::*;

  logic [POS_W-1:0] exp_pos_q;

  // track the position the next output beat must carry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_pos_q <= '0;
    end else if (out_valid_o && out_ready_i) begin
      exp_pos_q <= last_out_o ? '0 : position_o + 1'b1;
    end
  end

  // a stalled output beat holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(smoothed_o) &&
    $stable(position_o) && $stable(last_out_o))
    else $error("output beat changed while stalled");

  // outputs of a vector leave in order, restarting after the last one
  a_pos_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> position_o == exp_pos_q)
    else $error("output position out of sequence");

  // a sample beat is worked on before the next one is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while previous sample in work");

  // a waiting sample beat holds its payload
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(sample_i) &&
    $stable(is_last_i))
    else $error("input beat changed while waiting");

  // register writes land only while the block is idle
  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o && in_ready_o && !out_valid_o &&
    !$isunknown({cfg_index_i, cfg_data_i}))
    else $error("register write while block busy");

endmodule

bind gaussian_edge_shrinking_smoother gesmo_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (.*);

>>> tb/gesmo_scoreboard.sv
// Scoreboard for the Gaussian edge-shrinking smoother: tracks register writes
// and the sample ring, predicts every output beat and compares it in order.
// Depends on gesmo_pkg; instantiated beside the block by the testbench top.
module gesmo_scoreboard #(
  parameter int SAMPLE_BITS = gesmo_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_RADIUS  = gesmo_pkg::MAX_RADIUS_DEF,
  parameter int MAX_LENGTH  = gesmo_pkg::MAX_LENGTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  logic signed [SAMPLE_BITS-1:0]   sample_i,
  input  logic                            is_last_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  logic signed [SAMPLE_BITS-1:0]   smoothed_i,
  input  logic [gesmo_pkg::POS_W-1:0]     position_i,
  input  logic                            last_out_i,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_i,
  input  logic [gesmo_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [gesmo_pkg::CFG_DAT_W-1:0] cfg_data_i,
  output int unsigned                     error_count_o,
  output int unsigned                     pending_o
);
  import gesmo_pkg::*;

  localparam int RING_DEPTH   = 2 * MAX_RADIUS + 1;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] smoothed;
    logic [POS_W-1:0]              position;
    logic                          last_out;
  } out_beat_t;

  // shadow of the register file and of the sample ring
  logic [RADIUS_W-1:0]           radius_q;
  logic [WEIGHT_W-1:0]           tap_weight [MAX_RADIUS+1];
  logic signed [SAMPLE_BITS-1:0] ring [RING_DEPTH];
  int                            rx_count;
  int                            emit_count;
  int unsigned                   errors;
  out_beat_t                     expected_q [$];

  // Gaussian-weighted mean of samples center-half..center+half, rounded half
  // away from zero; all-zero weights pass the center sample through
  function automatic logic signed [SAMPLE_BITS-1:0] window_mean(int center, int half);
    longint acc, wsum, mag, quo, peak;
    int d, tap_dist;
    acc  = 0;
    wsum = 0;
    peak = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    for (d = 0; d <= 2 * half; d++) begin
      tap_dist = (d > half) ? d - half : half - d;
      acc  += longint'(ring[(center - half + d) % RING_DEPTH]) * longint'(tap_weight[tap_dist]);
      wsum += longint'(tap_weight[tap_dist]);
    end
    if (wsum == 0) return ring[center % RING_DEPTH];
    mag = (acc < 0) ? -acc : acc;
    quo = (2 * mag + wsum) / (2 * wsum);
    if (quo > peak + 1) quo = peak + 1;
    if (acc < 0) quo = -quo;
    if (quo > peak) quo = peak;
    if (quo < -peak - 1) quo = -peak - 1;
    return quo[SAMPLE_BITS-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    out_beat_t want;
    int d, j, i, half, rad, made, widx;
    logic vec_end, done;
    if (!rst_ni) begin
      radius_q = RADIUS_RESET;
      for (d = 0; d <= MAX_RADIUS; d++) begin
        tap_weight[d] = (d < NUM_RESET_WEIGHTS) ? WEIGHT_RESET[d] : '0;
      end
      for (d = 0; d < RING_DEPTH; d++) ring[d] = '0;
      rx_count   = 0;
      emit_count = 0;
      errors     = 0;
      expected_q.delete();
      error_count_o <= 0;
      pending_o     <= 0;
    end else begin
      // apply register writes
      if (cfg_valid_i && cfg_ready_i) begin
        widx = int'(cfg_index_i) - int'(REG_WEIGHT_0);
        if (cfg_index_i == REG_RADIUS) begin
          radius_q = cfg_data_i[RADIUS_W-1:0];
        end else if (widx >= 0 && widx <= MAX_RADIUS) begin
          tap_weight[widx] = cfg_data_i;
        end
      end

      // compare an output beat with the oldest prediction
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT) begin
            $display("unexpected output beat: smoothed %0d position %0d last %0b",
                     smoothed_i, position_i, last_out_i);
          end
        end else begin
          want = expected_q.pop_front();
          if (smoothed_i !== want.smoothed || position_i !== want.position ||
              last_out_i !== want.last_out) begin
            errors++;
            if (errors <= REPORT_LIMIT) begin
              $display("mismatch: expected %0d pos %0d last %0b, got %0d %0d %0b",
                       want.smoothed, want.position, want.last_out,
                       smoothed_i, position_i, last_out_i);
            end
          end
        end
      end

      // store the sample and predict every output it releases
      if (in_valid_i && in_ready_i) begin
        j       = rx_count;
        vec_end = is_last_i;
        rad     = (int'(radius_q) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_q);
        ring[j % RING_DEPTH] = sample_i;
        rx_count = j + 1;
        if (j + 1 >= MAX_LENGTH) vec_end = 1'b1;
        made = 0;
        done = 1'b0;
        while (!done && made <= MAX_RADIUS && emit_count <= j) begin
          i    = emit_count;
          half = (i < rad) ? i : rad;
          if (!vec_end && i + half > j) begin
            done = 1'b1;
          end else begin
            // shrink the window at the tail of the vector
            if (vec_end && j - i < half) half = j - i;
            want.smoothed = window_mean(i, half);
            want.position = i[POS_W-1:0];
            want.last_out = vec_end && (i == j);
            expected_q.push_back(want);
            emit_count = i + 1;
            made++;
          end
        end
        if (vec_end) begin
          rx_count   = 0;
          emit_count = 0;
        end
      end

      error_count_o <= errors;
      pending_o     <= expected_q.size();
    end
  end

endmodule

>>> tb/gaussian_edge_shrinking_smoother_tb.sv
// Testbench top for the Gaussian edge-shrinking smoother: drives directed and
// random sample vectors, register settings and output back-pressure.
// Depends on gesmo_pkg, the block and gesmo_scoreboard, which does the checking.
module gaussian_edge_shrinking_smoother_tb;
  import gesmo_pkg::*;

  localparam int SAMPLE_BITS    = SAMPLE_BITS_DEF;
  localparam int MAX_RADIUS     = MAX_RADIUS_DEF;
  localparam int MAX_LENGTH     = MAX_LENGTH_DEF;
  localparam int SETTLE_CYCLES  = 64;
  localparam int DRAIN_CYCLES   = 300;
  localparam int HOLDOFF_CYCLES = 600;
  localparam int STALL_LIMIT    = 20000;
  localparam int RANDOM_PHASES  = 5;
  localparam int PHASE_ITEMS    = 20;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [WEIGHT_W-1:0]           WEIGHT_ONE = 16'h8000;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample    = '0;
  logic                          is_last   = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [SAMPLE_BITS-1:0] smoothed;
  logic [POS_W-1:0]              position;
  logic                          last_out;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_DAT_W-1:0]          cfg_data  = '0;

  int unsigned         errors;
  int unsigned         pending;
  logic                sender_idles   = 1'b1;
  logic                receiver_idles = 1'b1;
  int                  holdoff_asks   = 0;
  int                  holdoffs_done  = 0;
  int                  holdoff_left   = 0;
  int                  stall_cycles   = 0;
  logic [WEIGHT_W-1:0] wt_plan [MAX_RADIUS+1];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  gaussian_edge_shrinking_smoother #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_RADIUS  (MAX_RADIUS),
    .MAX_LENGTH  (MAX_LENGTH)
  ) uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample),
    .is_last_i   (is_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .smoothed_o  (smoothed),
    .position_o  (position),
    .last_out_o  (last_out),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  gesmo_scoreboard #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .MAX_RADIUS  (MAX_RADIUS),
    .MAX_LENGTH  (MAX_LENGTH)
  ) scoreboard (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .sample_i      (sample),
    .is_last_i     (is_last),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .smoothed_i    (smoothed),
    .position_i    (position),
    .last_out_i    (last_out),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_i   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .error_count_o (errors),
    .pending_o     (pending)
  );

  // output side: random idling, plus a long hold-off when asked for
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
      out_ready    <= 1'b0;
    end else if (holdoff_asks != holdoffs_done) begin
      holdoffs_done <= holdoffs_done + 1;
      holdoff_left  <= HOLDOFF_CYCLES;
      out_ready     <= 1'b0;
    end else begin
      out_ready <= !(receiver_idles && $urandom_range(99) < 6);
    end
  end

  // abort when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // biased toward the extremes so every sample bit toggles
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return SAMPLE_BITS'($urandom_range(15)) - SAMPLE_BITS'(8);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(4))
      0:       return '0;
      1:       return WEIGHT_ONE;
      default: return WEIGHT_W'($urandom_range(32768));
    endcase
  endfunction

  // offer one sample beat and hold it until accepted
  task automatic push_sample(input logic signed [SAMPLE_BITS-1:0] value, input logic tail);
    if (sender_idles && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    is_last  <= tail;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending, wait for every predicted beat, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the radius and all weights from wt_plan, back to back
  task automatic load_settings(input logic [RADIUS_W-1:0] rad);
    int n;
    for (n = 0; n <= MAX_RADIUS + 1; n++) begin
      cfg_valid <= 1'b1;
      if (n == 0) begin
        cfg_index <= REG_RADIUS;
        cfg_data  <= CFG_DAT_W'(rad);
      end else begin
        cfg_index <= REG_WEIGHT_0 + CFG_IDX_W'(n - 1);
        cfg_data  <= wt_plan[n - 1];
      end
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int phase, n, len, sent;
    logic [RADIUS_W-1:0] rad;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: short vector of extremes and small values, then a single-element vector
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b0);
    push_sample(SAMPLE_BITS'(0), 1'b0);
    push_sample(SAMPLE_BITS'(-1), 1'b0);
    push_sample(SAMPLE_BITS'(1), 1'b1);
    push_sample(SAMPLE_MIN, 1'b1);

    // flat full-scale weights, radius above the maximum
    drain_results();
    for (n = 0; n <= MAX_RADIUS; n++) wt_plan[n] = WEIGHT_ONE;
    load_settings(3'd7);
    for (n = 0; n < 13; n++) push_sample((n % 2) ? SAMPLE_MIN : SAMPLE_MAX, n == 12);

    // all weights zero: center sample passes through
    drain_results();
    for (n = 0; n <= MAX_RADIUS; n++) wt_plan[n] = '0;
    load_settings(3'd3);
    push_sample(SAMPLE_BITS'(-5), 1'b0);
    push_sample(SAMPLE_MAX, 1'b0);
    push_sample(SAMPLE_MIN, 1'b1);

    // radius changed inside a vector; weights chosen to hit a rounding tie
    drain_results();
    for (n = 0; n <= MAX_RADIUS; n++) wt_plan[n] = (n == 0) ? 16'd2 : (n == 1) ? 16'd1 : 16'd0;
    load_settings(3'd0);
    push_sample(SAMPLE_BITS'(100), 1'b0);
    push_sample(SAMPLE_BITS'(-200), 1'b0);
    push_sample(SAMPLE_BITS'(1), 1'b0);
    drain_results();
    load_settings(3'd1);
    push_sample(SAMPLE_BITS'(0), 1'b0);
    push_sample(SAMPLE_BITS'(1), 1'b0);
    push_sample(SAMPLE_BITS'(-1), 1'b1);

    // random vectors under several settings
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      if (phase == 0) begin
        rad = RADIUS_W'(MAX_RADIUS);
        for (n = 0; n <= MAX_RADIUS; n++) wt_plan[n] = WEIGHT_ONE;
      end else begin
        rad = RADIUS_W'($urandom_range(7));
        for (n = 0; n <= MAX_RADIUS; n++) wt_plan[n] = pick_weight();
      end
      load_settings(rad);
      sender_idles   <= (phase != 2);
      receiver_idles <= (phase != 2);
      // hold the output off so the block backs up into its input
      if (phase == 3) holdoff_asks <= holdoff_asks + 1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 20);
        for (n = 0; n < len; n++) push_sample(pick_sample(), n == len - 1);
        sent += len;
      end
    end

    // wait out the last results, then give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> gaussian_edge_shrinking_smoother.f
design/gesmo_pkg.sv
design/gesmo_cell.sv
design/gesmo_mac.sv
design/gesmo_div.sv
design/gaussian_edge_shrinking_smoother.sv
design/gesmo_checker.sv
tb/gesmo_scoreboard.sv
tb/gaussian_edge_shrinking_smoother_tb.sv
